FILE: rtl/core/ptsu_pkg.sv
package ptsu_pkg;

	typedef enum logic [2:0] {
		ST_UNUSED   = 3'd0,
		ST_SLEEPING = 3'd1,
		ST_RUNNABLE = 3'd2,
		ST_RUNNING  = 3'd3,
		ST_ZOMBIE   = 3'd4
	} slot_state_t;

	typedef enum logic [3:0] {
		OP_TICK    = 4'd0,
		OP_ALLOC   = 4'd1,
		OP_WAKE    = 4'd2,
		OP_SLEEP   = 4'd3,
		OP_YIELD   = 4'd4,
		OP_EXIT    = 4'd5,
		OP_FREE    = 4'd6,
		OP_PICK    = 4'd7,
		OP_SETPRIO = 4'd8,
		OP_STATS   = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		RES_OK    = 2'd0,
		RES_NONE  = 2'd1,
		RES_WRONG = 2'd2
	} res_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_TICK_RD,
		S_TICK_WR,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_SLOT_RD,
		S_SLOT_EXEC,
		S_BURST_MUL,
		S_BURST_DIV,
		S_PICK_RD,
		S_PICK_CHK,
		S_PICK_MUL,
		S_PICK_DIV,
		S_PICK_END,
		S_PICK_WR
	} fsm_t;

	typedef struct packed {
		slot_state_t st;
		logic [2:0]  prio;
		logic [31:0] queue_time;
		logic [31:0] burst_avg;
		logic [31:0] run_total;
		logic [31:0] ready_total;
		logic [31:0] sleep_total;
		logic [31:0] dispatch_time;
		logic [31:0] sleep_start;
	} slot_word_t;

	typedef struct packed {
		logic go;
		logic short_div;
	} div_req_t;

	localparam logic [1:0] POL_RR    = 2'd0;
	localparam logic [1:0] POL_FCFS  = 2'd1;
	localparam logic [1:0] POL_SRT   = 2'd2;
	localparam logic [1:0] POL_RATIO = 2'd3;

	localparam logic [2:0] CFG_POLICY  = 3'd0;
	localparam logic [2:0] CFG_ALPHA   = 3'd1;
	localparam logic [2:0] CFG_IBURST  = 3'd2;
	localparam logic [2:0] CFG_DECAY0  = 3'd3;
	localparam logic [2:0] CFG_DECAY1  = 3'd4;
	localparam logic [2:0] CFG_DECAY2  = 3'd5;
	localparam logic [2:0] CFG_DECAY3  = 3'd6;
	localparam logic [2:0] CFG_DECAY4  = 3'd7;

	localparam logic [2:0]  PRIO_NORMAL = 3'd2;
	localparam logic [2:0]  PRIO_MAX    = 3'd4;
	localparam logic [6:0]  PERCENT     = 7'd100;
	localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;

	// ceil(2^27/100) and ceil(2^33/100): exact for 20-bit and 26-bit dividends
	localparam logic [20:0] RECIP_HI    = 21'd1342178;
	localparam logic [26:0] RECIP_LO    = 27'd85899346;

	function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? SAT32 : s[31:0];
	endfunction

endpackage

FILE: rtl/core/ptsu_div.sv
module ptsu_div
	import ptsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	input  logic [39:0] dividend,
	input  logic [32:0] divisor,
	output logic        done,
	output logic [39:0] quotient
);

	localparam logic [5:0] STEPS_SHORT = 6'd8;
	localparam logic [5:0] STEPS_LONG  = 6'd40;

	logic        run_q, done_q;
	logic [5:0]  cnt_q;
	logic [33:0] rem_q;
	logic [39:0] sh_q, quo_q;
	logic [32:0] dvs_q;
	logic [33:0] trial;
	logic        ge;

	assign trial = {rem_q[32:0], sh_q[39]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= req.short_div ? STEPS_SHORT : STEPS_LONG;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// short mode: quotient known to fit in 8 bits
	always_ff @(posedge clk) begin
		if (req.go) begin
			dvs_q <= divisor;
			quo_q <= '0;
			if (req.short_div) begin
				rem_q <= {2'b00, dividend[39:8]};
				sh_q  <= {dividend[7:0], 32'd0};
			end else begin
				rem_q <= '0;
				sh_q  <= dividend;
			end
		end else if (run_q) begin
			rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
			sh_q  <= {sh_q[38:0], 1'b0};
			quo_q <= {quo_q[38:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/process_table_scheduler_unit.sv
// channel   | handshake           | beat
// ----------+---------------------+----------------------------------------------
// event     | start & !busy       | opcode, slot, priority_level
// result    | done (one cycle)    | chosen_slot, status, avg_burst, run_ticks,
//           |                     | ready_ticks, sleep_ticks
// config    | cfg_we              | cfg_index, cfg_data
//
// One event at a time; the slot table sits in one single-port-read memory.
// Tick reads and writes back each slot; pick reads and checks each slot, then
// reads and writes the chosen one; allocate reads and checks slots until one is free.
// The ratio policy adds a divider run per runnable slot with a non-zero sum. Sleep,
// yield and exit end in a three-step reciprocal divide by 100. After reset a clearing
// pass runs with busy high. done is a single-cycle strobe; the receiver cannot stall it.
module process_table_scheduler_unit
	import ptsu_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  opcode,
	input  logic [5:0]  slot,
	input  logic [2:0]  priority_level,
	output logic        done,
	output logic [5:0]  chosen_slot,
	output logic [1:0]  status,
	output logic [31:0] avg_burst,
	output logic [31:0] run_ticks,
	output logic [31:0] ready_ticks,
	output logic [31:0] sleep_ticks,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

	function automatic logic [SW-1:0] nxt(logic [SW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	fsm_t        state_q, state_d;
	logic [SW-1:0] idx_q, idx_d, cnt_q, cnt_d, best_q, best_d, rr_q, rr_d;
	logic        found_q, found_d, seen_q, seen_d;
	logic [31:0] tick_q, tick_d, bk_q, bk_d;
	op_t         op_q;
	logic [5:0]  slot_q;
	logic [2:0]  lvl_q;
	slot_word_t  word_q, word_d;
	logic [32:0] sum_q, sum_d;

	logic [1:0]  policy_q;
	logic [6:0]  alpha_q;
	logic [15:0] ib_q;
	logic [7:0]  decay_q [5];

	slot_word_t  slot_mem [SLOTS];
	slot_word_t  rd_word_q;
	logic        mem_we, mem_re;
	logic [SW-1:0] mem_waddr, mem_raddr;
	slot_word_t  mem_wdata;

	div_req_t    div_req;
	logic [39:0] div_dividend, div_quo;
	logic [32:0] div_divisor;
	logic        div_done;

	logic        fin;
	logic [SW-1:0] fin_chosen;
	res_t        fin_res;
	logic [31:0] fin_avg, fin_run, fin_rdy, fin_slp;

	logic        done_q;
	logic [5:0]  chosen_q;
	res_t        status_q;
	logic [31:0] avg_q, run_q, rdy_q, slp_q;

	logic [SW-1:0] saddr;
	logic [6:0]  alpha_eff;
	logic [31:0] cur;
	logic [38:0] bm1, bm2;
	logic [2:0]  pr;
	logic [39:0] rk_num;

	logic [38:0] bx_q;
	logic [13:0] bqh_q;
	logic [25:0] by_q;
	logic [1:0]  bstep_q, bstep_d;
	logic [40:0] hi_prod;
	logic [6:0]  hi_rem;
	logic [52:0] lo_prod;
	logic [32:0] bq;

	ptsu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (mem_we)
			slot_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_word_q <= slot_mem[mem_raddr];
	end

	assign saddr     = SW'(slot_q);
	assign alpha_eff = (alpha_q > PERCENT) ? PERCENT : alpha_q;
	assign cur       = tick_q - word_q.dispatch_time;
	assign bm1       = 39'(alpha_eff) * 39'(cur);
	assign bm2       = 39'(PERCENT - alpha_eff) * 39'(word_q.burst_avg);
	assign pr        = (word_q.prio > PRIO_MAX) ? PRIO_MAX : word_q.prio;
	assign rk_num    = 40'(word_q.run_total) * 40'(decay_q[pr]);

	// x/100 = (xh/100)*2^19 + ((xh%100)*2^19 + xl)/100
	assign hi_prod   = 41'(bx_q[38:19]) * 41'(RECIP_HI);
	assign hi_rem    = 7'(bx_q[38:19] - 20'(bqh_q) * 20'(PERCENT));
	assign lo_prod   = 53'(by_q) * 53'(RECIP_LO);
	assign bq        = {bqh_q, 19'd0} + 33'(lo_prod[52:33]);

	always_comb begin
		slot_word_t  w;
		logic [31:0] key;
		logic        cmp;
		logic        adv;
		state_d   = state_q;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		best_d    = best_q;
		rr_d      = rr_q;
		found_d   = found_q;
		seen_d    = seen_q;
		tick_d    = tick_q;
		bk_d      = bk_q;
		word_d    = word_q;
		sum_d     = sum_q;
		bstep_d   = bstep_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = idx_q;
		mem_raddr = idx_q;
		mem_wdata = '0;
		div_req   = '0;
		div_dividend = '0;
		div_divisor  = 33'(PERCENT);
		fin        = 1'b0;
		fin_chosen = '0;
		fin_res    = RES_OK;
		fin_avg    = '0;
		fin_run    = '0;
		fin_rdy    = '0;
		fin_slp    = '0;
		w   = rd_word_q;
		key = '0;
		cmp = 1'b0;
		adv = 1'b0;

		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				idx_d  = nxt(idx_q);
				if (idx_q == LAST_IDX)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					case (op_t'(opcode))
						OP_TICK: begin
							tick_d  = sat_add32(tick_q, 32'd1);
							idx_d   = '0;
							state_d = S_TICK_RD;
						end
						OP_ALLOC: begin
							idx_d   = '0;
							state_d = S_ALLOC_RD;
						end
						OP_PICK: begin
							idx_d   = (policy_q == POL_RR) ? rr_q : '0;
							cnt_d   = '0;
							found_d = 1'b0;
							seen_d  = 1'b0;
							state_d = S_PICK_RD;
						end
						OP_WAKE, OP_SLEEP, OP_YIELD, OP_EXIT, OP_FREE,
						OP_SETPRIO, OP_STATS: begin
							if (32'(slot) < 32'(SLOTS))
								state_d = S_SLOT_RD;
							else begin
								fin     = 1'b1;
								fin_res = RES_WRONG;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_TICK_RD: begin
				mem_re  = 1'b1;
				state_d = S_TICK_WR;
			end
			S_TICK_WR: begin
				if (w.st == ST_RUNNABLE)
					w.ready_total = sat_add32(w.ready_total, 32'd1);
				else if (w.st == ST_RUNNING)
					w.run_total = sat_add32(w.run_total, 32'd1);
				mem_we    = 1'b1;
				mem_wdata = w;
				idx_d     = nxt(idx_q);
				if (idx_q == LAST_IDX) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else
					state_d = S_TICK_RD;
			end
			S_ALLOC_RD: begin
				mem_re  = 1'b1;
				state_d = S_ALLOC_CHK;
			end
			S_ALLOC_CHK: begin
				if (w.st == ST_UNUSED) begin
					mem_wdata               = '0;
					mem_wdata.st            = ST_RUNNABLE;
					mem_wdata.prio          = PRIO_NORMAL;
					mem_wdata.queue_time    = tick_q;
					mem_wdata.dispatch_time = tick_q;
					mem_wdata.burst_avg     = 32'(ib_q);
					mem_we     = 1'b1;
					fin        = 1'b1;
					fin_chosen = idx_q;
					state_d    = S_IDLE;
				end else if (idx_q == LAST_IDX) begin
					fin     = 1'b1;
					fin_res = RES_NONE;
					state_d = S_IDLE;
				end else begin
					idx_d   = nxt(idx_q);
					state_d = S_ALLOC_RD;
				end
			end
			S_SLOT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = saddr;
				state_d   = S_SLOT_EXEC;
			end
			S_SLOT_EXEC: begin
				word_d    = w;
				mem_waddr = saddr;
				state_d   = S_IDLE;
				fin       = 1'b1;
				case (op_q)
					OP_WAKE: begin
						if (w.st != ST_SLEEPING)
							fin_res = RES_WRONG;
						else begin
							w.st          = ST_RUNNABLE;
							w.queue_time  = tick_q;
							w.sleep_total = sat_add32(w.sleep_total,
								tick_q - w.sleep_start);
							mem_we    = 1'b1;
							mem_wdata = w;
						end
					end
					OP_SLEEP, OP_YIELD, OP_EXIT: begin
						if (w.st != ST_RUNNING)
							fin_res = RES_WRONG;
						else begin
							fin     = 1'b0;
							state_d = S_BURST_MUL;
						end
					end
					OP_FREE: begin
						if (w.st != ST_ZOMBIE)
							fin_res = RES_WRONG;
						else begin
							mem_we    = 1'b1;
							mem_wdata = '0;
						end
					end
					OP_SETPRIO: begin
						if (w.st == ST_UNUSED)
							fin_res = RES_WRONG;
						else begin
							w.prio    = (lvl_q > PRIO_MAX) ? PRIO_MAX : lvl_q;
							mem_we    = 1'b1;
							mem_wdata = w;
						end
					end
					OP_STATS: begin
						if (w.st == ST_UNUSED)
							fin_res = RES_WRONG;
						else begin
							fin_avg = w.burst_avg;
							fin_run = w.run_total;
							fin_rdy = w.ready_total;
							fin_slp = w.sleep_total;
						end
					end
					default: ;
				endcase
			end
			S_BURST_MUL: begin
				bstep_d = 2'd0;
				state_d = S_BURST_DIV;
			end
			S_BURST_DIV: begin
				if (bstep_q == 2'd2) begin
					w = word_q;
					w.burst_avg = bq[32] ? SAT32 : bq[31:0];
					case (op_q)
						OP_SLEEP: begin
							w.st          = ST_SLEEPING;
							w.sleep_start = tick_q;
						end
						OP_YIELD: begin
							w.st         = ST_RUNNABLE;
							w.queue_time = tick_q;
						end
						default: w.st = ST_ZOMBIE;
					endcase
					mem_we    = 1'b1;
					mem_waddr = saddr;
					mem_wdata = w;
					fin       = 1'b1;
					state_d   = S_IDLE;
				end else
					bstep_d = bstep_q + 2'd1;
			end
			S_PICK_RD: begin
				mem_re  = 1'b1;
				state_d = S_PICK_CHK;
			end
			S_PICK_CHK: begin
				word_d = w;
				adv    = 1'b1;
				if (w.st == ST_RUNNING)
					seen_d = 1'b1;
				if (w.st == ST_RUNNABLE && !(policy_q == POL_RR && found_q)) begin
					case (policy_q)
						POL_RR: begin
							found_d = 1'b1;
							best_d  = idx_q;
						end
						POL_FCFS: begin
							key = w.queue_time;
							cmp = 1'b1;
						end
						POL_SRT: begin
							key = w.burst_avg;
							cmp = 1'b1;
						end
						default: begin
							sum_d = 33'(w.run_total) + 33'(w.sleep_total);
							if (sum_d == 33'd0)
								cmp = 1'b1;
							else begin
								adv     = 1'b0;
								state_d = S_PICK_MUL;
							end
						end
					endcase
				end
			end
			S_PICK_MUL: begin
				div_req.go        = 1'b1;
				div_req.short_div = 1'b1;
				div_dividend      = rk_num;
				div_divisor       = sum_q;
				state_d           = S_PICK_DIV;
			end
			S_PICK_DIV: begin
				div_divisor = sum_q;
				if (div_done) begin
					key = 32'(div_quo[7:0]);
					cmp = 1'b1;
					adv = 1'b1;
				end
			end
			S_PICK_END: begin
				if (seen_q) begin
					fin     = 1'b1;
					fin_res = RES_WRONG;
					state_d = S_IDLE;
				end else if (!found_q) begin
					fin     = 1'b1;
					fin_res = RES_NONE;
					state_d = S_IDLE;
				end else begin
					if (policy_q == POL_RR)
						rr_d = nxt(best_q);
					mem_re    = 1'b1;
					mem_raddr = best_q;
					state_d   = S_PICK_WR;
				end
			end
			S_PICK_WR: begin
				w.st            = ST_RUNNING;
				w.dispatch_time = tick_q;
				mem_we     = 1'b1;
				mem_waddr  = best_q;
				mem_wdata  = w;
				fin        = 1'b1;
				fin_chosen = best_q;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase

		if (cmp && (!found_q || key < bk_q)) begin
			found_d = 1'b1;
			best_d  = idx_q;
			bk_d    = key;
		end
		if (adv) begin
			if (cnt_q == LAST_IDX)
				state_d = S_PICK_END;
			else begin
				cnt_d   = cnt_q + 1'b1;
				idx_d   = nxt(idx_q);
				state_d = S_PICK_RD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			idx_q    <= '0;
			cnt_q    <= '0;
			found_q  <= 1'b0;
			seen_q   <= 1'b0;
			tick_q   <= '0;
			rr_q     <= '0;
			bstep_q  <= '0;
			policy_q <= POL_FCFS;
			alpha_q  <= 7'd50;
			ib_q     <= 16'd500;
			decay_q[0] <= 8'd1;
			decay_q[1] <= 8'd3;
			decay_q[2] <= 8'd5;
			decay_q[3] <= 8'd7;
			decay_q[4] <= 8'd25;
			done_q   <= 1'b0;
			chosen_q <= '0;
			status_q <= RES_OK;
			avg_q    <= '0;
			run_q    <= '0;
			rdy_q    <= '0;
			slp_q    <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			found_q <= found_d;
			seen_q  <= seen_d;
			tick_q  <= tick_d;
			rr_q    <= rr_d;
			bstep_q <= bstep_d;
			done_q  <= fin;
			if (fin) begin
				chosen_q <= 6'(fin_chosen);
				status_q <= fin_res;
				avg_q    <= fin_avg;
				run_q    <= fin_run;
				rdy_q    <= fin_rdy;
				slp_q    <= fin_slp;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_POLICY: policy_q <= cfg_data[1:0];
					CFG_ALPHA:  alpha_q  <= cfg_data[6:0];
					CFG_IBURST: ib_q     <= cfg_data;
					CFG_DECAY0, CFG_DECAY1, CFG_DECAY2, CFG_DECAY3, CFG_DECAY4:
						decay_q[cfg_index - CFG_DECAY0] <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
		sum_q  <= sum_d;
		best_q <= best_d;
		bk_q   <= bk_d;
		if (state_q == S_IDLE && start) begin
			op_q   <= op_t'(opcode);
			slot_q <= slot;
			lvl_q  <= priority_level;
		end
		if (state_q == S_BURST_MUL)
			bx_q <= bm1 + bm2;
		if (state_q == S_BURST_DIV && bstep_q == 2'd0)
			bqh_q <= hi_prod[40:27];
		if (state_q == S_BURST_DIV && bstep_q == 2'd1)
			by_q <= {hi_rem, bx_q[18:0]};
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign chosen_slot = chosen_q;
	assign status      = status_q;
	assign avg_burst   = avg_q;
	assign run_ticks   = run_q;
	assign ready_ticks = rdy_q;
	assign sleep_ticks = slp_q;

	a_fail_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != RES_OK |-> chosen_slot == 6'd0)
		else $error("failed event reports a slot");

	a_fail_no_stats: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != RES_OK |-> avg_burst == 32'd0 && run_ticks == 32'd0 &&
			ready_ticks == 32'd0 && sleep_ticks == 32'd0)
		else $error("failed event reports stats");

	a_rr_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rr_q) < 32'(SLOTS))
		else $error("round robin pointer out of range");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q != S_IDLE)
		else $error("table written while idle");

	a_ok_means_done: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> done && !busy)
		else $error("result beat lost");

endmodule
